/* src/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skip it while reset is low.
`define BQSE_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("bqse: property violated");

// Flag a condition that must never be seen outside reset.
`define BQSE_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("bqse: forbidden condition seen");

`endif

/* src/bqse_pkg.sv */
// ----------------------------------------------------------------------------
// bqse_pkg
// Types, constants and helpers for the bilinear quad shape evaluator.
// ----------------------------------------------------------------------------
package bqse_pkg;

	localparam int COORD_FRAC_BITS = 16;
	localparam int ONE_Q14 = 16384;
	localparam int HALF_F = 1 << (COORD_FRAC_BITS - 1);
	// quotient carries 2F-16 fraction bits plus one rounding bit
	localparam int DIV_SHIFT = 2 * COORD_FRAC_BITS - 15;
	localparam int Q_W = 34;
	localparam int DIV_STAGES = Q_W;

	// corner sign bits: set means the sign is minus
	localparam logic [3:0] S_NEG = 4'b1001;
	localparam logic [3:0] T_NEG = 4'b0011;

	typedef logic signed [31:0] coord_t;
	typedef logic signed [15:0] natc_t;
	typedef logic signed [16:0] nat_t;
	typedef logic signed [33:0] ab_t;
	typedef logic signed [48:0] prod_t;
	typedef logic signed [50:0] acc_t;
	typedef logic signed [49:0] num_t;
	typedef logic [49:0] un_t;
	typedef logic signed [64:0] det_t;
	typedef logic [63:0] ud_t;
	typedef logic [14:0] shp_t;
	typedef logic [Q_W-1:0] quo_t;

	typedef struct packed {
		logic [1:0] node;
		shp_t shp;
		coord_t detq;
		logic sing;
		logic negx;
		logic negy;
		logic ovfx;
		logic ovfy;
		ud_t ud;
		un_t unx;
		un_t uny;
		ud_t rx;
		ud_t ry;
		quo_t qx;
		quo_t qy;
	} div_stage_t;

	localparam coord_t SAT_MAX = 32'sh7FFF_FFFF;
	localparam coord_t SAT_MIN = 32'sh8000_0000;

	function automatic coord_t sat32(det_t v);
		coord_t r;
		if (v > det_t'(SAT_MAX)) begin
			r = SAT_MAX;
		end else if (v < det_t'(SAT_MIN)) begin
			r = SAT_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// one restoring step: shift in a bit, subtract the divisor if it fits
	function automatic logic [64:0] div_step(ud_t r, ud_t d, logic b);
		logic [64:0] tr;
		logic [64:0] dd;
		logic [64:0] res;
		tr = {r, b};
		dd = {1'b0, d};
		if (tr >= dd) begin
			res = {1'b1, 64'(tr - dd)};
		end else begin
			res = {1'b0, tr[63:0]};
		end
		return res;
	endfunction

endpackage

/* src/bilinear_quad_shape_eval_core.sv */
// ----------------------------------------------------------------------------
// bilinear_quad_shape_eval_core
// Quad4 shape functions, Jacobian, determinant and global derivatives.
// ----------------------------------------------------------------------------
// Takes one item (four corners and a natural point) per accepted start, and
// can take a new item while earlier ones are still in the pipeline. Busy stays
// high after each accepted start, because an item leaves as four node results,
// one per cycle, on the single result port. The results of an item come out
// on consecutive cycles with node_index 0..3; last_node marks the fourth. The
// global derivatives come from the two 34-stage restoring dividers at the end
// of the pipeline. There is no result back-pressure: result_valid pulses for
// one cycle per result and the receiver must take it then.
module bilinear_quad_shape_eval_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  bqse_pkg::coord_t     node0_x,
	input  bqse_pkg::coord_t     node1_x,
	input  bqse_pkg::coord_t     node2_x,
	input  bqse_pkg::coord_t     node3_x,
	input  bqse_pkg::coord_t     node0_y,
	input  bqse_pkg::coord_t     node1_y,
	input  bqse_pkg::coord_t     node2_y,
	input  bqse_pkg::coord_t     node3_y,
	input  bqse_pkg::natc_t      nat_s,
	input  bqse_pkg::natc_t      nat_t,
	output logic                 result_valid,
	output logic [1:0]           node_index,
	output logic                 last_node,
	output bqse_pkg::shp_t       shape_value,
	output bqse_pkg::coord_t     deriv_x,
	output bqse_pkg::coord_t     deriv_y,
	output bqse_pkg::coord_t     jacobian_det,
	output logic                 singular
);

	logic [1:0] gap_q;
	logic accept;

	assign accept = start && !busy;
	assign busy = (gap_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= 2'd0;
		end else if (accept) begin
			gap_q <= 2'd3;
		end else if (gap_q != 2'd0) begin
			gap_q <= gap_q - 2'd1;
		end
	end

	// ---------------- stage 1: input capture
	logic v_s1;
	bqse_pkg::coord_t x_s1 [4];
	bqse_pkg::coord_t y_s1 [4];
	bqse_pkg::natc_t s_s1, t_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1[0] <= node0_x;
			x_s1[1] <= node1_x;
			x_s1[2] <= node2_x;
			x_s1[3] <= node3_x;
			y_s1[0] <= node0_y;
			y_s1[1] <= node1_y;
			y_s1[2] <= node2_y;
			y_s1[3] <= node3_y;
			s_s1 <= nat_s;
			t_s1 <= nat_t;
		end
	end

	// ---------------- stage 2: natural derivatives and coordinate products
	bqse_pkg::nat_t a_c [4];
	bqse_pkg::nat_t b_c [4];
	bqse_pkg::nat_t ds_c [4];
	bqse_pkg::nat_t dt_c [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			a_c[i] = bqse_pkg::S_NEG[i] ?
				bqse_pkg::nat_t'(bqse_pkg::ONE_Q14) - bqse_pkg::nat_t'(s_s1) :
				bqse_pkg::nat_t'(bqse_pkg::ONE_Q14) + bqse_pkg::nat_t'(s_s1);
			b_c[i] = bqse_pkg::T_NEG[i] ?
				bqse_pkg::nat_t'(bqse_pkg::ONE_Q14) - bqse_pkg::nat_t'(t_s1) :
				bqse_pkg::nat_t'(bqse_pkg::ONE_Q14) + bqse_pkg::nat_t'(t_s1);
			ds_c[i] = bqse_pkg::S_NEG[i] ? -b_c[i] : b_c[i];
			dt_c[i] = bqse_pkg::T_NEG[i] ? -a_c[i] : a_c[i];
		end
	end

	logic v_s2;
	bqse_pkg::prod_t pxs_s2 [4];
	bqse_pkg::prod_t pxt_s2 [4];
	bqse_pkg::prod_t pys_s2 [4];
	bqse_pkg::prod_t pyt_s2 [4];
	bqse_pkg::nat_t ds_s2 [4];
	bqse_pkg::nat_t dt_s2 [4];
	bqse_pkg::ab_t ab_s2 [4];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			pxs_s2[i] <= bqse_pkg::prod_t'(x_s1[i]) * bqse_pkg::prod_t'(ds_c[i]);
			pxt_s2[i] <= bqse_pkg::prod_t'(x_s1[i]) * bqse_pkg::prod_t'(dt_c[i]);
			pys_s2[i] <= bqse_pkg::prod_t'(y_s1[i]) * bqse_pkg::prod_t'(ds_c[i]);
			pyt_s2[i] <= bqse_pkg::prod_t'(y_s1[i]) * bqse_pkg::prod_t'(dt_c[i]);
			ds_s2[i] <= ds_c[i];
			dt_s2[i] <= dt_c[i];
			ab_s2[i] <= bqse_pkg::ab_t'(a_c[i]) * bqse_pkg::ab_t'(b_c[i]);
		end
	end

	// ---------------- stage 3: Jacobian entries and shape values
	function automatic bqse_pkg::coord_t jround(bqse_pkg::prod_t p0, bqse_pkg::prod_t p1,
		bqse_pkg::prod_t p2, bqse_pkg::prod_t p3);
		bqse_pkg::acc_t acc;
		bqse_pkg::acc_t accr;
		acc = bqse_pkg::acc_t'(p0) + bqse_pkg::acc_t'(p1) +
			bqse_pkg::acc_t'(p2) + bqse_pkg::acc_t'(p3);
		// round half away from zero in one add, then floor shift
		accr = acc + (acc[50] ? bqse_pkg::acc_t'(32767) : bqse_pkg::acc_t'(32768));
		return bqse_pkg::sat32(bqse_pkg::det_t'(accr >>> 16));
	endfunction

	function automatic bqse_pkg::shp_t sround(bqse_pkg::ab_t ab);
		bqse_pkg::ab_t abr;
		bqse_pkg::ab_t sh;
		bqse_pkg::shp_t r;
		abr = ab + (ab[33] ? bqse_pkg::ab_t'(32767) : bqse_pkg::ab_t'(32768));
		sh = abr >>> 16;
		if (sh[33]) begin
			r = '0;
		end else if (sh > bqse_pkg::ab_t'(32767)) begin
			r = '1;
		end else begin
			r = sh[14:0];
		end
		return r;
	endfunction

	logic v_s3;
	bqse_pkg::coord_t j00_s3, j01_s3, j10_s3, j11_s3;
	bqse_pkg::nat_t ds_s3 [4];
	bqse_pkg::nat_t dt_s3 [4];
	bqse_pkg::shp_t shp_s3 [4];

	always_ff @(posedge clk) begin
		j00_s3 <= jround(pxs_s2[0], pxs_s2[1], pxs_s2[2], pxs_s2[3]);
		j01_s3 <= jround(pxt_s2[0], pxt_s2[1], pxt_s2[2], pxt_s2[3]);
		j10_s3 <= jround(pys_s2[0], pys_s2[1], pys_s2[2], pys_s2[3]);
		j11_s3 <= jround(pyt_s2[0], pyt_s2[1], pyt_s2[2], pyt_s2[3]);
		for (int i = 0; i < 4; i++) begin
			ds_s3[i] <= ds_s2[i];
			dt_s3[i] <= dt_s2[i];
			shp_s3[i] <= sround(ab_s2[i]);
		end
	end

	// ---------------- stage 4: determinant products
	logic v_s4;
	bqse_pkg::det_t pd0_s4, pd1_s4;
	bqse_pkg::coord_t j00_s4, j01_s4, j10_s4, j11_s4;
	bqse_pkg::nat_t ds_s4 [4];
	bqse_pkg::nat_t dt_s4 [4];
	bqse_pkg::shp_t shp_s4 [4];

	always_ff @(posedge clk) begin
		pd0_s4 <= bqse_pkg::det_t'(j00_s3) * bqse_pkg::det_t'(j11_s3);
		pd1_s4 <= bqse_pkg::det_t'(j01_s3) * bqse_pkg::det_t'(j10_s3);
		j00_s4 <= j00_s3;
		j01_s4 <= j01_s3;
		j10_s4 <= j10_s3;
		j11_s4 <= j11_s3;
		ds_s4 <= ds_s3;
		dt_s4 <= dt_s3;
		shp_s4 <= shp_s3;
	end

	// ---------------- stage 5: determinant
	logic v_s5;
	bqse_pkg::det_t det_s5;
	bqse_pkg::coord_t j00_s5, j01_s5, j10_s5, j11_s5;
	bqse_pkg::nat_t ds_s5 [4];
	bqse_pkg::nat_t dt_s5 [4];
	bqse_pkg::shp_t shp_s5 [4];

	always_ff @(posedge clk) begin
		det_s5 <= pd0_s4 - pd1_s4;
		j00_s5 <= j00_s4;
		j01_s5 <= j01_s4;
		j10_s5 <= j10_s4;
		j11_s5 <= j11_s4;
		ds_s5 <= ds_s4;
		dt_s5 <= dt_s4;
		shp_s5 <= shp_s4;
	end

	// ---------------- node sequencer: hold one item, walk its four nodes
	bqse_pkg::det_t detr_c;
	bqse_pkg::coord_t detq_c;
	logic sing_c;

	always_comb begin
		detr_c = det_s5 + (det_s5[64] ? bqse_pkg::det_t'(bqse_pkg::HALF_F - 1) :
			bqse_pkg::det_t'(bqse_pkg::HALF_F));
		sing_c = (det_s5 == '0);
		detq_c = sing_c ? '0 :
			bqse_pkg::sat32(detr_c >>> bqse_pkg::COORD_FRAC_BITS);
	end

	logic run_q;
	logic [1:0] node_q;
	bqse_pkg::coord_t j00_q, j01_q, j10_q, j11_q, detq_q;
	bqse_pkg::nat_t ds_q [4];
	bqse_pkg::nat_t dt_q [4];
	bqse_pkg::shp_t shp_q [4];
	bqse_pkg::ud_t ud_q;
	logic dneg_q, sing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			node_q <= 2'd0;
		end else if (v_s5) begin
			run_q <= 1'b1;
			node_q <= 2'd0;
		end else if (run_q) begin
			node_q <= node_q + 2'd1;
			if (node_q == 2'd3) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s5) begin
			j00_q <= j00_s5;
			j01_q <= j01_s5;
			j10_q <= j10_s5;
			j11_q <= j11_s5;
			ds_q <= ds_s5;
			dt_q <= dt_s5;
			shp_q <= shp_s5;
			detq_q <= detq_c;
			sing_q <= sing_c;
			dneg_q <= det_s5[64];
			ud_q <= det_s5[64] ? bqse_pkg::ud_t'(-det_s5) : bqse_pkg::ud_t'(det_s5);
		end
	end

	// ---------------- stage 6: numerator products for the current node
	logic v_s6;
	bqse_pkg::prod_t pa_s6, pb_s6, pc_s6, pd_s6;
	logic [1:0] node_s6;
	bqse_pkg::shp_t shp_s6;
	bqse_pkg::coord_t detq_s6;
	logic sing_s6, dneg_s6;
	bqse_pkg::ud_t ud_s6;

	always_ff @(posedge clk) begin
		pa_s6 <= bqse_pkg::prod_t'(ds_q[node_q]) * bqse_pkg::prod_t'(j11_q);
		pb_s6 <= bqse_pkg::prod_t'(dt_q[node_q]) * bqse_pkg::prod_t'(j10_q);
		pc_s6 <= bqse_pkg::prod_t'(dt_q[node_q]) * bqse_pkg::prod_t'(j00_q);
		pd_s6 <= bqse_pkg::prod_t'(ds_q[node_q]) * bqse_pkg::prod_t'(j01_q);
		node_s6 <= node_q;
		shp_s6 <= shp_q[node_q];
		detq_s6 <= detq_q;
		sing_s6 <= sing_q;
		dneg_s6 <= dneg_q;
		ud_s6 <= ud_q;
	end

	// ---------------- stage 7: numerators
	logic v_s7;
	bqse_pkg::num_t nx_s7, ny_s7;
	logic [1:0] node_s7;
	bqse_pkg::shp_t shp_s7;
	bqse_pkg::coord_t detq_s7;
	logic sing_s7, dneg_s7;
	bqse_pkg::ud_t ud_s7;

	always_ff @(posedge clk) begin
		nx_s7 <= bqse_pkg::num_t'(pa_s6) - bqse_pkg::num_t'(pb_s6);
		ny_s7 <= bqse_pkg::num_t'(pc_s6) - bqse_pkg::num_t'(pd_s6);
		node_s7 <= node_s6;
		shp_s7 <= shp_s6;
		detq_s7 <= detq_s6;
		sing_s7 <= sing_s6;
		dneg_s7 <= dneg_s6;
		ud_s7 <= ud_s6;
	end

	// ---------------- stage 8: magnitudes and result signs
	logic v_s8;
	bqse_pkg::un_t unx_s8, uny_s8;
	logic negx_s8, negy_s8;
	logic [1:0] node_s8;
	bqse_pkg::shp_t shp_s8;
	bqse_pkg::coord_t detq_s8;
	logic sing_s8;
	bqse_pkg::ud_t ud_s8;

	always_ff @(posedge clk) begin
		unx_s8 <= nx_s7[49] ? bqse_pkg::un_t'(-nx_s7) : bqse_pkg::un_t'(nx_s7);
		uny_s8 <= ny_s7[49] ? bqse_pkg::un_t'(-ny_s7) : bqse_pkg::un_t'(ny_s7);
		negx_s8 <= nx_s7[49] ^ dneg_s7;
		negy_s8 <= ny_s7[49] ^ dneg_s7;
		node_s8 <= node_s7;
		shp_s8 <= shp_s7;
		detq_s8 <= detq_s7;
		sing_s8 <= sing_s7;
		ud_s8 <= ud_s7;
	end

	// ---------------- divider pipeline: one quotient bit per stage
	bqse_pkg::div_stage_t dv_q [bqse_pkg::DIV_STAGES+1];
	logic [bqse_pkg::DIV_STAGES:0] dvv_q;
	bqse_pkg::ud_t r0x_c, r0y_c;

	// top dividend bits above the quotient window
	assign r0x_c = bqse_pkg::ud_t'(unx_s8 >> (bqse_pkg::Q_W - bqse_pkg::DIV_SHIFT));
	assign r0y_c = bqse_pkg::ud_t'(uny_s8 >> (bqse_pkg::Q_W - bqse_pkg::DIV_SHIFT));

	always_ff @(posedge clk) begin
		dv_q[0].node <= node_s8;
		dv_q[0].shp <= shp_s8;
		dv_q[0].detq <= detq_s8;
		dv_q[0].sing <= sing_s8;
		dv_q[0].negx <= negx_s8;
		dv_q[0].negy <= negy_s8;
		// quotient would not fit in the pipeline width: saturate
		dv_q[0].ovfx <= (r0x_c >= ud_s8);
		dv_q[0].ovfy <= (r0y_c >= ud_s8);
		dv_q[0].ud <= ud_s8;
		dv_q[0].unx <= unx_s8;
		dv_q[0].uny <= uny_s8;
		dv_q[0].rx <= r0x_c;
		dv_q[0].ry <= r0y_c;
		dv_q[0].qx <= '0;
		dv_q[0].qy <= '0;
	end

	for (genvar k = 0; k < bqse_pkg::DIV_STAGES; k++) begin : g_div
		localparam int JB = bqse_pkg::Q_W - 1 - k;
		logic bx, by;
		logic [64:0] stx, sty;
		bqse_pkg::div_stage_t dn_c;

		if (JB >= bqse_pkg::DIV_SHIFT) begin : g_bit
			assign bx = dv_q[k].unx[JB - bqse_pkg::DIV_SHIFT];
			assign by = dv_q[k].uny[JB - bqse_pkg::DIV_SHIFT];
		end else begin : g_zero
			assign bx = 1'b0;
			assign by = 1'b0;
		end

		assign stx = bqse_pkg::div_step(dv_q[k].rx, dv_q[k].ud, bx);
		assign sty = bqse_pkg::div_step(dv_q[k].ry, dv_q[k].ud, by);

		always_comb begin
			dn_c = dv_q[k];
			dn_c.rx = stx[63:0];
			dn_c.ry = sty[63:0];
			dn_c.qx = {dv_q[k].qx[bqse_pkg::Q_W-2:0], stx[64]};
			dn_c.qy = {dv_q[k].qy[bqse_pkg::Q_W-2:0], sty[64]};
		end

		always_ff @(posedge clk) begin
			dv_q[k+1] <= dn_c;
		end
	end

	// valid bits for every stage in one place
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			dvv_q <= '0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= run_q;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			dvv_q <= {dvv_q[bqse_pkg::DIV_STAGES-1:0], v_s8};
		end
	end

	// ---------------- output: round the quotient and saturate
	function automatic bqse_pkg::coord_t qfinish(bqse_pkg::quo_t q, logic ovf, logic neg);
		bqse_pkg::quo_t qr;
		bqse_pkg::coord_t r;
		qr = bqse_pkg::Q_W'(({1'b0, q} + {{bqse_pkg::Q_W{1'b0}}, 1'b1}) >> 1);
		if (neg) begin
			if (ovf || (qr > bqse_pkg::quo_t'(34'h0_8000_0000))) begin
				r = bqse_pkg::SAT_MIN;
			end else begin
				r = -bqse_pkg::coord_t'(qr[31:0]);
			end
		end else begin
			if (ovf || (qr > bqse_pkg::quo_t'(34'h0_7FFF_FFFF))) begin
				r = bqse_pkg::SAT_MAX;
			end else begin
				r = bqse_pkg::coord_t'(qr[31:0]);
			end
		end
		return r;
	endfunction

	bqse_pkg::div_stage_t dl;
	assign dl = dv_q[bqse_pkg::DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= dvv_q[bqse_pkg::DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		node_index <= dl.node;
		last_node <= (dl.node == 2'd3);
		shape_value <= dl.shp;
		jacobian_det <= dl.detq;
		singular <= dl.sing;
		deriv_x <= dl.sing ? '0 : qfinish(dl.qx, dl.ovfx, dl.negx);
		deriv_y <= dl.sing ? '0 : qfinish(dl.qy, dl.ovfy, dl.negy);
	end

endmodule

/* src/bqse_checker.sv */
// ----------------------------------------------------------------------------
// bqse_checker
// Port-level checks for the bilinear quad shape evaluator, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bqse_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             result_valid,
	input logic [1:0]       node_index,
	input logic             last_node,
	input bqse_pkg::coord_t deriv_x,
	input bqse_pkg::coord_t deriv_y,
	input bqse_pkg::coord_t jacobian_det,
	input logic             singular
);

	// an accepted item keeps busy high, blocking the next start
	`BQSE_ASSERT(a_busy_after_accept, clk, arst_n, (start && !busy) |=> busy ##1 busy ##1 busy)

	`BQSE_ASSERT(a_last_is_node3, clk, arst_n, (result_valid && last_node) |-> (node_index == 2'd3))

	`BQSE_ASSERT(a_singular_zero, clk, arst_n,
		(result_valid && singular) |-> (deriv_x == '0 && deriv_y == '0 && jacobian_det == '0))

	// nodes of one item come out on consecutive cycles
	`BQSE_ASSERT(a_node_order, clk, arst_n,
		(result_valid && node_index != 2'd0) |->
		($past(result_valid) && ($past(node_index) == node_index - 2'd1)))

	`BQSE_NEVER(a_no_lone_node0, clk, arst_n,
		result_valid && node_index == 2'd0 && $past(result_valid) && !$past(last_node))

endmodule

bind bilinear_quad_shape_eval_core bqse_checker u_bqse_checker (.*);

/* dv/tb_bilinear_quad_shape_eval_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bilinear_quad_shape_eval_core
// Self-checking bench for the quad4 shape function and Jacobian evaluator.
// ----------------------------------------------------------------------------
// A short table of hand-picked elements runs first: the unit square at its
// center and corners, singular and degenerate shapes, coordinate and natural
// point extremes, tiny and inverted elements. Random elements follow, mostly
// well-formed quads with random size and jitter, mixed with raw noise. Every
// accepted item is run through a bit-exact fixed-point predictor that yields
// four node results, and each result strobe is compared field by field.
// ----------------------------------------------------------------------------
module tb_bilinear_quad_shape_eval_core;
	import bqse_pkg::*;

	localparam int HALF_PERIOD = 2;
	localparam int N_RANDOM = 210;
	localparam int IDLE_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		coord_t x[4];
		coord_t y[4];
		natc_t s;
		natc_t t;
	} quad_pt_t;

	typedef struct {
		quad_pt_t q;
		logic typed;
		logic e_sing;
		coord_t e_det;
	} table_row_t;

	typedef struct {
		logic [1:0] node;
		logic last;
		shp_t shp;
		coord_t gx;
		coord_t gy;
		coord_t det;
		logic sing;
	} node_res_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	coord_t node0_x, node1_x, node2_x, node3_x;
	coord_t node0_y, node1_y, node2_y, node3_y;
	natc_t nat_s, nat_t;
	logic result_valid;
	logic [1:0] node_index;
	logic last_node;
	shp_t shape_value;
	coord_t deriv_x, deriv_y, jacobian_det;
	logic singular;

	node_res_t node_q[$];
	table_row_t stim_table[$];
	int errors = 0;
	int n_items = 0;
	int n_results = 0;
	int n_singular = 0;
	int idle_cnt = 0;
	logic typed_pending = 1'b0;
	logic typed_sing;
	coord_t typed_det;

	bilinear_quad_shape_eval_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.node0_x(node0_x), .node1_x(node1_x), .node2_x(node2_x), .node3_x(node3_x),
		.node0_y(node0_y), .node1_y(node1_y), .node2_y(node2_y), .node3_y(node3_y),
		.nat_s(nat_s), .nat_t(nat_t),
		.result_valid(result_valid), .node_index(node_index), .last_node(last_node),
		.shape_value(shape_value), .deriv_x(deriv_x), .deriv_y(deriv_y),
		.jacobian_det(jacobian_det), .singular(singular)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	function automatic longint unsigned abs64(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	// round v / 2^sh half away from zero
	function automatic longint round_shift(longint v, int sh);
		longint unsigned m;
		m = abs64(v);
		m = (m + (64'd1 << (sh - 1))) >> sh;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// round(num * 2^k / den), half away from zero, saturated
	function automatic coord_t quotient_fix(longint num, longint den, int k);
		logic neg;
		logic sat;
		longint unsigned un, ud, q, r;
		neg = (num < 0) != (den < 0);
		un = abs64(num);
		ud = abs64(den);
		q = un / ud;
		r = un % ud;
		sat = q > 64'hF_FFFF_FFFF;
		for (int i = 0; i <= k && !sat; i++) begin
			q = q << 1;
			if (r >= ud - r) begin
				q = q | 64'd1;
				r = r - (ud - r);
			end else begin
				r = r + r;
			end
			if (q > 64'hF_FFFF_FFFF) sat = 1'b1;
		end
		if (sat) return neg ? SAT_MIN : SAT_MAX;
		q = (q + 1) >> 1;
		if (neg) return q > 64'h8000_0000 ? SAT_MIN : coord_t'(-longint'(q));
		return q > 64'h7FFF_FFFF ? SAT_MAX : coord_t'(q);
	endfunction

	task automatic predict_nodes(input quad_pt_t q);
		longint a, b, n, sgn_s, sgn_t, j00, j01, j10, j11, det;
		longint ds[4], dt[4], acc[4];
		shp_t shp[4];
		node_res_t r;
		logic sing;
		coord_t detq;
		acc = '{0, 0, 0, 0};
		for (int i = 0; i < 4; i++) begin
			sgn_s = S_NEG[i] ? -1 : 1;
			sgn_t = T_NEG[i] ? -1 : 1;
			a = ONE_Q14 + sgn_s * longint'(q.s);
			b = ONE_Q14 + sgn_t * longint'(q.t);
			n = round_shift(a * b, 16);
			if (n < 0) n = 0;
			if (n > 32767) n = 32767;
			shp[i] = shp_t'(n);
			ds[i] = sgn_s * b;
			dt[i] = sgn_t * a;
			acc[0] += longint'(q.x[i]) * ds[i];
			acc[1] += longint'(q.x[i]) * dt[i];
			acc[2] += longint'(q.y[i]) * ds[i];
			acc[3] += longint'(q.y[i]) * dt[i];
		end
		j00 = clamp32(round_shift(acc[0], 16));
		j01 = clamp32(round_shift(acc[1], 16));
		j10 = clamp32(round_shift(acc[2], 16));
		j11 = clamp32(round_shift(acc[3], 16));
		det = j00 * j11 - j01 * j10;
		sing = (det == 0);
		detq = sing ? '0 : coord_t'(clamp32(round_shift(det, COORD_FRAC_BITS)));
		for (int i = 0; i < 4; i++) begin
			r.node = i[1:0];
			r.last = (i == 3);
			r.shp = shp[i];
			r.det = detq;
			r.sing = sing;
			r.gx = '0;
			r.gy = '0;
			if (!sing) begin
				r.gx = quotient_fix(ds[i] * j11 - dt[i] * j10, det, 2 * COORD_FRAC_BITS - 16);
				r.gy = quotient_fix(dt[i] * j00 - ds[i] * j01, det, 2 * COORD_FRAC_BITS - 16);
			end
			// hand-typed rows override the determinant and flag
			if (typed_pending) begin
				r.sing = typed_sing;
				r.det = typed_det;
			end
			node_q.push_back(r);
		end
		if (sing) n_singular++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// accepted items and results are both seen at the rising edge
	always @(posedge clk) begin
		node_res_t e;
		if (arst_n) begin
			if (start && !busy) begin
				predict_nodes('{x: '{node0_x, node1_x, node2_x, node3_x},
					y: '{node0_y, node1_y, node2_y, node3_y}, s: nat_s, t: nat_t});
				n_items++;
			end
			if (result_valid) begin
				n_results++;
				if (node_q.size() == 0) begin
					$error("result with no item outstanding, node %0d", node_index);
					errors++;
				end else begin
					e = node_q.pop_front();
					check_field("node_index", e.node, node_index);
					check_field("last_node", e.last, last_node);
					check_field("shape_value", e.shp, shape_value);
					check_field("deriv_x", e.gx, deriv_x);
					check_field("deriv_y", e.gy, deriv_y);
					check_field("jacobian_det", e.det, jacobian_det);
					check_field("singular", e.sing, singular);
				end
			end
			if ((start && !busy) || result_valid) begin
				idle_cnt <= 0;
			end else if (idle_cnt >= IDLE_LIMIT) begin
				$display("timeout: no activity for %0d cycles", IDLE_LIMIT);
				$display("status: fail");
				$finish;
			end else begin
				idle_cnt <= idle_cnt + 1;
			end
		end
	end

	function automatic quad_pt_t make_quad(coord_t x0, coord_t x1, coord_t x2, coord_t x3,
			coord_t y0, coord_t y1, coord_t y2, coord_t y3, int s, int t);
		quad_pt_t q;
		q.x = '{x0, x1, x2, x3};
		q.y = '{y0, y1, y2, y3};
		q.s = natc_t'(s);
		q.t = natc_t'(t);
		return q;
	endfunction

	function automatic coord_t pick_extreme();
		case ($urandom_range(0, 5))
			0: return SAT_MIN;
			1: return SAT_MAX;
			2: return 32'sd0;
			3: return -32'sd1;
			4: return 32'sd1;
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic quad_pt_t rand_quad();
		quad_pt_t q;
		int mode, sz, cx, cy;
		mode = $urandom_range(0, 9);
		if (mode <= 5) begin
			// well-formed counterclockwise quad with random size and jitter
			sz = 1 << $urandom_range(2, 24);
			cx = $signed($urandom) >>> 5;
			cy = $signed($urandom) >>> 5;
			q.x = '{cx - sz, cx + sz, cx + sz, cx - sz};
			q.y = '{cy - sz, cy - sz, cy + sz, cy + sz};
			for (int i = 0; i < 4; i++) begin
				q.x[i] += int'($urandom_range(0, sz)) - sz / 2;
				q.y[i] += int'($urandom_range(0, sz)) - sz / 2;
			end
			if (mode == 5) begin
				// clockwise order flips the determinant
				q.x = '{q.x[0], q.x[3], q.x[2], q.x[1]};
				q.y = '{q.y[0], q.y[3], q.y[2], q.y[1]};
			end
		end else if (mode == 6) begin
			for (int i = 0; i < 4; i++) begin
				q.x[i] = coord_t'($urandom);
				q.y[i] = coord_t'($urandom);
			end
		end else if (mode == 7) begin
			// points on one line
			cx = $signed($urandom) >>> 8;
			cy = $signed($urandom) >>> 8;
			for (int i = 0; i < 4; i++) begin
				q.x[i] = cx * i;
				q.y[i] = cy * i;
			end
		end else if (mode == 8) begin
			for (int i = 0; i < 4; i++) begin
				q.x[i] = pick_extreme();
				q.y[i] = pick_extreme();
			end
		end else begin
			for (int i = 0; i < 4; i++) begin
				q.x[i] = int'($urandom_range(0, 6)) - 3;
				q.y[i] = int'($urandom_range(0, 6)) - 3;
			end
		end
		case ($urandom_range(0, 9))
			0, 1: begin
				q.s = natc_t'($urandom);
				q.t = natc_t'($urandom);
			end
			2: begin
				q.s = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
				q.t = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
			end
			default: begin
				q.s = natc_t'(int'($urandom_range(0, 32768)) - 16384);
				q.t = natc_t'(int'($urandom_range(0, 32768)) - 16384);
			end
		endcase
		return q;
	endfunction

	task automatic apply_inputs(input quad_pt_t q);
		node0_x = q.x[0]; node1_x = q.x[1]; node2_x = q.x[2]; node3_x = q.x[3];
		node0_y = q.y[0]; node1_y = q.y[1]; node2_y = q.y[2]; node3_y = q.y[3];
		nat_s = q.s;
		nat_t = q.t;
	endtask

	// hold the item until an edge with busy low takes it
	task automatic send_item(input quad_pt_t q, input int idle_pct);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct && gap < 20) begin
			@(negedge clk);
			start = 1'b0;
			apply_inputs(rand_quad());
			gap++;
		end
		@(negedge clk);
		apply_inputs(q);
		start = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	localparam coord_t U1 = 32'sd65536;

	initial begin
		int idle_pct;
		int phase_pct[5];
		quad_pt_t q;
		table_row_t row;
		phase_pct = '{0, 68, 35, 68, 0};
		arst_n = 1'b0;
		start = 1'b0;
		apply_inputs(make_quad(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

		// unit square, center: J = diag(0.5, 0.5), det = 0.25
		row = '{make_quad(0, U1, U1, 0, 0, 0, U1, U1, 0, 0), 1'b1, 1'b0, 32'sd16384};
		stim_table.push_back(row);
		row.typed = 1'b0;
		row.q = make_quad(0, U1, U1, 0, 0, 0, U1, U1, -16384, -16384);
		stim_table.push_back(row);
		row.q = make_quad(0, U1, U1, 0, 0, 0, U1, U1, 16384, 16384);
		stim_table.push_back(row);
		row.q = make_quad(0, U1, U1, 0, 0, 0, U1, U1, 16384, -16384);
		stim_table.push_back(row);
		row.q = make_quad(0, U1, U1, 0, 0, 0, U1, U1, -32768, 32767);
		stim_table.push_back(row);
		row.q = make_quad(0, U1, U1, 0, 0, 0, U1, U1, 32767, -32768);
		stim_table.push_back(row);
		// all nodes at one point: singular
		row = '{make_quad(0, 0, 0, 0, 0, 0, 0, 0, 1234, -777), 1'b1, 1'b1, 32'sd0};
		stim_table.push_back(row);
		row.q = make_quad(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
			SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 0, 0);
		stim_table.push_back(row);
		row.typed = 1'b0;
		// collinear nodes
		row.q = make_quad(0, U1, 2 * U1, 3 * U1, 0, U1, 2 * U1, 3 * U1, 100, -100);
		stim_table.push_back(row);
		// extreme spread: Jacobian and determinant saturate
		row.q = make_quad(SAT_MIN, SAT_MAX, SAT_MAX, SAT_MIN,
			SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX, 0, 0);
		stim_table.push_back(row);
		row.q = make_quad(SAT_MAX, SAT_MIN, SAT_MIN, SAT_MAX,
			SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX, 5000, 9000);
		stim_table.push_back(row);
		// tiny elements: huge derivatives
		row.q = make_quad(0, 1, 1, 0, 0, 0, 1, 1, 0, 0);
		stim_table.push_back(row);
		row.q = make_quad(0, 2, 2, 0, 0, 0, 1, 1, 3000, -16384);
		stim_table.push_back(row);
		// clockwise order: negative determinant
		row.q = make_quad(0, 0, U1, U1, 0, U1, U1, 0, 0, 0);
		stim_table.push_back(row);
		// skewed, negative coordinates, odd point
		row.q = make_quad(-3 * U1, U1, 2 * U1, -U1, -U1, -2 * U1, U1, 3 * U1, -8191, 12345);
		stim_table.push_back(row);
		row.q = make_quad(-1, -1, -1, -1, 32'sh5555_5555, 32'shAAAA_AAAA, 1, -2,
			-21846, 21845);
		stim_table.push_back(row);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (stim_table[i]) begin
			@(negedge clk);
			typed_pending = stim_table[i].typed;
			typed_sing = stim_table[i].e_sing;
			typed_det = stim_table[i].e_det;
			send_item(stim_table[i].q, 0);
		end
		@(negedge clk);
		typed_pending = 1'b0;
		start = 1'b0;

		for (int i = 0; i < N_RANDOM; i++) begin
			idle_pct = phase_pct[i * 5 / N_RANDOM];
			q = rand_quad();
			send_item(q, idle_pct);
		end
		@(negedge clk);
		start = 1'b0;

		while (node_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d elements (%0d singular), %0d node results checked",
			n_items, n_singular, n_results);
		$display("table rows plus random quads under no, light and heavy start gaps");
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", errors);
			$display("status: fail");
		end
		$finish;
	end

endmodule
